FILE: hw/rtl/osss_pkg.sv
// Package for the order statistic sorted set: request and result types,
// mode codes and the control word broadcast along the cell chain.
// No dependencies.
package osss_pkg;

  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_ERASE    = 3'd1;
  localparam logic [2:0] MODE_CONTAINS = 3'd2;
  localparam logic [2:0] MODE_PRED     = 3'd3;
  localparam logic [2:0] MODE_RANK     = 3'd4;
  localparam logic [2:0] MODE_SELECT   = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [15:0]        rank_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] key_out;
    logic [6:0]         rank_out;
    logic [6:0]         set_size;
    logic               full_drop;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
    logic rd_pred;
    logic rd_sel;
  } cell_op_t;

endpackage

FILE: hw/rtl/osss_cell.sv
// One slot of the sorted key chain: holds a key, compares it with the
// broadcast request key and shifts with its neighbors on insert and erase.
// Depends on osss_pkg.
module osss_cell #(
  parameter int IDX = 0,
  parameter int KW  = 32,
  parameter int CW  = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  osss_pkg::cell_op_t op_i,
  input  logic [KW-1:0]      key_i,
  input  logic [CW-1:0]      count_i,
  input  logic [15:0]        rank_i,
  input  logic [KW-1:0]      left_key_i,
  input  logic               left_lt_i,
  input  logic [KW-1:0]      right_key_i,
  input  logic               right_le_i,
  output logic [KW-1:0]      key_o,
  output logic               lt_o,
  output logic               le_o,
  output logic               eq_o,
  output logic               bound_o,
  output logic [KW-1:0]      rd_o
);
  import osss_pkg::*;

  logic [KW-1:0] key_q, key_d;
  logic          lt_q, le_q, eq_q, sel_q;
  logic          occ, sel_d, pred;
  logic [31:0]   rank32;

  assign occ    = 32'(count_i) > 32'(IDX);
  assign rank32 = {16'b0, rank_i};
  assign sel_d  = occ && (rank32 == 32'(IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      le_q  <= 1'b0;
      eq_q  <= 1'b0;
      sel_q <= 1'b0;
    end else if (op_i.cmp) begin
      lt_q  <= occ && ($signed(key_q) <  $signed(key_i));
      le_q  <= occ && ($signed(key_q) <= $signed(key_i));
      eq_q  <= occ && (key_q == key_i);
      sel_q <= sel_d;
    end
  end

  assign bound_o = left_lt_i && !lt_q;
  assign pred    = le_q && !right_le_i;

  always_comb begin
    key_d = key_q;
    if (op_i.ins) begin
      if (bound_o) begin
        key_d = key_i;
      end else if (!left_lt_i) begin
        key_d = left_key_i;
      end
    end else if (op_i.del && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign le_o  = le_q;
  assign eq_o  = eq_q;
  assign rd_o  = ((op_i.rd_pred && pred) || (op_i.rd_sel && sel_q)) ? key_q : '0;

endmodule

FILE: hw/rtl/order_statistic_sorted_set_unit.sv
// Order statistic sorted set: top level with request sequencer and cell chain.
// Depends on osss_pkg and osss_cell.
//
// After a request is accepted, every cell first compares its key with the
// request key and registers the outcome. Then the chain shifts for insert
// or erase while the position, predecessor or selected key is gathered
// from the cells and registered. The result appears on rsp_o with valid_o
// high for exactly one cycle and must be taken then, since the receiver
// cannot stall. busy is low in that cycle, so the next request can be
// accepted while the result is shown.
module order_statistic_sorted_set_unit #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  osss_pkg::req_t  req_i,
  output logic            valid_o,
  output osss_pkg::rsp_t  rsp_o
);
  import osss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = KEY_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_EVAL} state_e;

  state_e        state_q;
  req_t          req_q;
  logic [CW-1:0] count_q, count_d;
  logic          valid_q;
  rsp_t          rsp_q, rsp_d;

  logic [KW+31:0] key_ext;
  logic [KW-1:0]  key_w;
  cell_op_t       op;

  logic [KW-1:0] ckey [CAPACITY];
  logic [KW-1:0] crd  [CAPACITY];
  logic [CAPACITY-1:0] lt, le, eq, bnd;

  logic          present, full, ins, del;
  logic [CW-1:0] pos;
  logic [KW-1:0] rd_all;
  logic [KW+31:0] rd_ext;
  logic [CW+7:0]  pos_ext, cnt_ext;
  logic [31:0]    rank32;

  assign key_ext = {{KW{req_q.key[31]}}, req_q.key};
  assign key_w   = key_ext[KW-1:0];
  assign busy    = state_q != S_IDLE;

  assign present = |eq;
  assign full    = 32'(count_q) >= 32'(CAPACITY);
  assign ins     = (state_q == S_EVAL) && (req_q.mode == MODE_INSERT) && !present && !full;
  assign del     = (state_q == S_EVAL) && (req_q.mode == MODE_ERASE) && present;

  always_comb begin
    op         = '0;
    op.cmp     = state_q == S_CMP;
    op.ins     = ins;
    op.del     = del;
    op.rd_pred = req_q.mode == MODE_PRED;
    op.rd_sel  = req_q.mode == MODE_SELECT;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KW-1:0] lkey, rkey;
    logic          llt, rle;
    if (g == 0) begin : g_first
      assign lkey = ckey[g];
      assign llt  = 1'b1;
    end else begin : g_mid_l
      assign lkey = ckey[g-1];
      assign llt  = lt[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rkey = ckey[g];
      assign rle  = 1'b0;
    end else begin : g_mid_r
      assign rkey = ckey[g+1];
      assign rle  = le[g+1];
    end
    osss_cell #(.IDX(g), .KW(KW), .CW(CW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .key_i       (key_w),
      .count_i     (count_q),
      .rank_i      (req_q.rank_in),
      .left_key_i  (lkey),
      .left_lt_i   (llt),
      .right_key_i (rkey),
      .right_le_i  (rle),
      .key_o       (ckey[g]),
      .lt_o        (lt[g]),
      .le_o        (le[g]),
      .eq_o        (eq[g]),
      .bound_o     (bnd[g]),
      .rd_o        (crd[g])
    );
  end

  always_comb begin
    pos    = '0;
    rd_all = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        pos = pos | CW'(i);
      end
      rd_all = rd_all | crd[i];
    end
    if (lt[CAPACITY-1]) begin
      pos = pos | CW'(CAPACITY);
    end
  end

  assign rd_ext  = {32'b0, rd_all};
  assign pos_ext = {8'b0, pos};
  assign cnt_ext = {8'b0, count_d};
  assign rank32  = {16'b0, req_q.rank_in};

  always_comb begin
    count_d = count_q;
    if (ins) begin
      count_d = count_q + CW'(1);
    end else if (del) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    rsp_d          = '0;
    rsp_d.set_size = cnt_ext[6:0];
    case (req_q.mode)
      MODE_INSERT: begin
        rsp_d.hit       = ins;
        rsp_d.full_drop = !present && full;
      end
      MODE_ERASE:    rsp_d.hit = del;
      MODE_CONTAINS: rsp_d.hit = present;
      MODE_PRED: begin
        rsp_d.hit     = le[0];
        rsp_d.key_out = rd_ext[31:0];
      end
      MODE_RANK: begin
        rsp_d.hit      = 1'b1;
        rsp_d.rank_out = pos_ext[6:0];
      end
      MODE_SELECT: begin
        rsp_d.hit     = rank32 < 32'(count_q);
        rsp_d.key_out = rd_ext[31:0];
      end
      default: rsp_d.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
      rsp_q   <= '0;
    end else begin
      valid_q <= state_q == S_EVAL;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_CMP;
          end
        end
        S_CMP:  state_q <= S_EVAL;
        S_EVAL: begin
          state_q <= S_IDLE;
          count_q <= count_d;
          rsp_q   <= rsp_d;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: hw/rtl/osss_checker.sv
// Port-level checks for the order statistic sorted set, bound to the top.
// Depends on osss_pkg and order_statistic_sorted_set_unit.
module osss_checker #(
  parameter int CAPACITY = 64
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           valid_o,
  input osss_pkg::rsp_t rsp_o
);
  import osss_pkg::*;

  logic [31:0] size32;
  assign size32 = {25'b0, rsp_o.set_size};

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 valid_o)
    else $error("result missing three cycles after request");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_drop_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.full_drop |-> !rsp_o.hit && rsp_o.set_size == 7'(CAPACITY))
    else $error("dropped key reported as hit or set not full");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> size32 <= 32'(CAPACITY))
    else $error("set size above capacity");

endmodule

bind order_statistic_sorted_set_unit osss_checker #(.CAPACITY(CAPACITY)) u_osss_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for order_statistic_sorted_set_unit: drives requests of all
// six modes plus unused codes, mirrors the sorted set and checks every result.
// Depends on osss_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import osss_pkg::*;

  localparam int SET_CAPACITY = 64;
  localparam int RANDOM_REQUESTS = 850;
  localparam int PHASE_LEN = 160;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  class set_shadow;
    logic signed [31:0] stored_keys[$];
    rsp_t               pending_results[$];
    int unsigned        fail_count;
    int unsigned        result_count;
    int unsigned        drop_count;
    int unsigned        peak_size;

    function void note_request(req_t r);
      rsp_t exp_rsp;
      int   pos;
      bit   present;
      int   upto;
      pos = 0;
      foreach (stored_keys[i]) if (stored_keys[i] < r.key) pos++;
      present = 1'b0;
      if (pos < stored_keys.size()) present = (stored_keys[pos] == r.key);
      exp_rsp = '0;
      case (r.mode)
        MODE_INSERT: begin
          if (!present) begin
            if (stored_keys.size() >= SET_CAPACITY) begin
              exp_rsp.full_drop = 1'b1;
              drop_count++;
            end else begin
              stored_keys.insert(pos, r.key);
              exp_rsp.hit = 1'b1;
            end
          end
        end
        MODE_ERASE: begin
          if (present) begin
            stored_keys.delete(pos);
            exp_rsp.hit = 1'b1;
          end
        end
        MODE_CONTAINS: exp_rsp.hit = present;
        MODE_PRED: begin
          upto = pos + (present ? 1 : 0);
          if (upto > 0) begin
            exp_rsp.hit = 1'b1;
            exp_rsp.key_out = stored_keys[upto - 1];
          end
        end
        MODE_RANK: begin
          exp_rsp.hit = 1'b1;
          exp_rsp.rank_out = 7'(pos);
        end
        MODE_SELECT: begin
          if (int'(r.rank_in) < stored_keys.size()) begin
            exp_rsp.hit = 1'b1;
            exp_rsp.key_out = stored_keys[r.rank_in];
          end
        end
        default: ;
      endcase
      exp_rsp.set_size = 7'(stored_keys.size());
      if (stored_keys.size() > peak_size) peak_size = stored_keys.size();
      pending_results.push_back(exp_rsp);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_rsp;
      result_count++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with no request outstanding: %p", $realtime, got);
        return;
      end
      exp_rsp = pending_results.pop_front();
      if (got.hit !== exp_rsp.hit || got.key_out !== exp_rsp.key_out ||
          got.rank_out !== exp_rsp.rank_out || got.set_size !== exp_rsp.set_size ||
          got.full_drop !== exp_rsp.full_drop) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch hit %b/%b key_out %0d/%0d rank_out %0d/%0d",
                    " size %0d/%0d drop %b/%b"},
                   $realtime, exp_rsp.hit, got.hit, exp_rsp.key_out, got.key_out,
                   exp_rsp.rank_out, got.rank_out, exp_rsp.set_size, got.set_size,
                   exp_rsp.full_drop, got.full_drop);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function logic signed [31:0] any_stored();
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  req_t   req_i;
  logic   valid_o;
  rsp_t   rsp_o;

  set_shadow   shadow = new();
  int unsigned request_count;
  int unsigned sent;
  int unsigned guard;
  bit          idling_on;
  req_t        next_req;

  order_statistic_sorted_set_unit #(
    .CAPACITY (SET_CAPACITY),
    .KEY_WIDTH(32)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) shadow.check_result(rsp_o);
      if (start && !busy) begin
        shadow.note_request(req_i);
        request_count++;
      end
    end
  end

  function automatic req_t make_req(logic [2:0] mode, logic signed [31:0] key,
                                    logic [15:0] rank);
    req_t r;
    r.mode = mode;
    r.key = key;
    r.rank_in = rank;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_key(int unsigned stored_pct);
    logic signed [31:0] k;
    if (shadow.stored_keys.size() > 0 && $urandom_range(99) < stored_pct) begin
      k = shadow.any_stored();
      case ($urandom_range(3))
        0: k = k - 1;
        1: k = k + 1;
        default: ;
      endcase
      return k;
    end
    case ($urandom_range(9))
      0: k = KEY_MIN;
      1: k = KEY_MAX;
      2: k = $signed(32'($urandom_range(16))) - 8;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic req_t random_req(bit growing, output bit counted);
    req_t        r;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned era_pct;
    roll = $urandom_range(99);
    ins_pct = growing ? 50 : 15;
    era_pct = growing ? 8 : 40;
    counted = 1'b1;
    r.rank_in = ($urandom_range(4) == 0) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(70));
    if (roll >= 97) begin
      r.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      r.key = $urandom;
      r.rank_in = 16'($urandom);
      counted = 1'b0;
    end else if (roll < ins_pct) begin
      r.mode = MODE_INSERT;
      r.key = pick_key(20);
    end else if (roll < ins_pct + era_pct) begin
      r.mode = MODE_ERASE;
      r.key = pick_key(75);
    end else begin
      case (roll % 4)
        0: r.mode = MODE_CONTAINS;
        1: r.mode = MODE_PRED;
        2: r.mode = MODE_RANK;
        default: r.mode = MODE_SELECT;
      endcase
      r.key = pick_key(50);
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    guard = 0;
    while (shadow.outstanding() > 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(99) < 12) idle_gap($urandom_range(1, 5));
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    req_t        directed[$];
    bit          counted;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    idling_on = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(make_req(MODE_SELECT,   32'sd0,  16'd0));
    directed.push_back(make_req(MODE_PRED,     KEY_MIN, 16'd0));
    directed.push_back(make_req(MODE_RANK,     32'sd0,  16'd0));
    directed.push_back(make_req(MODE_ERASE,    32'sd5,  16'd0));
    directed.push_back(make_req(MODE_INSERT,   32'sd0,  16'd0));
    directed.push_back(make_req(MODE_INSERT,   KEY_MAX, 16'd0));
    directed.push_back(make_req(MODE_INSERT,   -32'sd1, 16'd0));
    directed.push_back(make_req(MODE_PRED,     KEY_MIN, 16'd0));
    directed.push_back(make_req(MODE_INSERT,   KEY_MIN, 16'd0));
    directed.push_back(make_req(MODE_INSERT,   32'sd0,  16'd0));
    directed.push_back(make_req(MODE_CONTAINS, KEY_MIN, 16'd0));
    directed.push_back(make_req(MODE_CONTAINS, 32'sd1,  16'd0));
    directed.push_back(make_req(MODE_PRED,     KEY_MIN, 16'd0));
    directed.push_back(make_req(MODE_PRED,     32'sd100, 16'd0));
    directed.push_back(make_req(MODE_PRED,     KEY_MAX, 16'd0));
    directed.push_back(make_req(MODE_RANK,     KEY_MAX, 16'd0));
    directed.push_back(make_req(MODE_SELECT,   32'sd0,  16'd3));
    directed.push_back(make_req(MODE_SELECT,   32'sd0,  16'd4));
    directed.push_back(make_req(MODE_SELECT,   32'sd0,  16'hffff));
    directed.push_back(make_req(MODE_ERASE,    -32'sd1, 16'd0));
    directed.push_back(make_req(MODE_ERASE,    -32'sd1, 16'd0));
    directed.push_back(make_req(MODE_SPARE_LO, 32'sd0,  16'd0));
    directed.push_back(make_req(MODE_SPARE_HI, KEY_MAX, 16'hffff));
    directed.push_back(make_req(MODE_RANK,     KEY_MIN, 16'd0));
    foreach (directed[i]) begin
      maybe_idle();
      send_req(directed[i]);
    end
    drain_results();

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      idling_on = !(sent >= 500 && sent < 650);
      if (sent % PHASE_LEN == 0 && sent != 0) drain_results();
      maybe_idle();
      next_req = random_req(((sent / PHASE_LEN) % 2) == 0, counted);
      send_req(next_req);
      if (counted) sent++;
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results from %0d requests; peak set size %0d, %0d %s",
             shadow.result_count, request_count, shadow.peak_size, shadow.drop_count,
             "inserts dropped when full.");
    $display("Mismatches or stray results: %0d, requests still outstanding: %0d.",
             shadow.fail_count, shadow.outstanding());
    if (shadow.fail_count == 0 && shadow.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
